FILE: hdl/lfu_cache_table_defines.svh
// ----------------------------------------------------------------------------
// LFU cache table assertion macros
// Shared property wrappers. Each one is clocked on i_clk and is off while
// i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_TABLE_DEFINES_SVH
`define LFU_CACHE_TABLE_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define LFU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lfu_cache_table: same-cycle check failed");

// Consequence must hold in the cycle after the antecedent.
`define LFU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lfu_cache_table: next-cycle check failed");

`endif

FILE: hdl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// LFU cache table package
// Field widths, operation codes and the control groups shared between the
// sequencer and the scan unit.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int STAMP_W = 32;
    localparam int CFG_W   = 7;

    localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    // sequencer to scan unit
    typedef struct packed {
        logic               start;
        logic               eval;
        logic [KEY_W-1:0]   find_key;
        logic [STAMP_W-1:0] stamp_now;
    } t_scan_ctl;

    // scan unit to sequencer
    typedef struct packed {
        logic hit;
        logic free_found;
        logic victim_found;
    } t_scan_sts;

endpackage

FILE: hdl/lfu_if.sv
// ----------------------------------------------------------------------------
// LFU cache table channels
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lfu_req_if;
    logic                      valid;
    logic                      ready;
    logic                      action;
    logic [lfu_pkg::KEY_W-1:0] key;
    logic [lfu_pkg::DATA_W-1:0] value;

    modport source (output valid, output action, output key, output value, input ready);
    modport sink   (input valid, input action, input key, input value, output ready);
endinterface

interface lfu_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       hit;
    logic [lfu_pkg::DATA_W-1:0] read_value;

    modport source (output valid, output hit, output read_value, input ready);
    modport sink   (input valid, input hit, input read_value, output ready);
endinterface

interface lfu_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [lfu_pkg::CFG_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/lfu_scan.sv
// ----------------------------------------------------------------------------
// LFU scan unit
// Evaluates one table entry per cycle: first key match, first free entry and
// the eviction victim (lowest count, then oldest stamp, then lowest index).
// ----------------------------------------------------------------------------
module lfu_scan #(
    parameter int ENTRIES    = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lfu_pkg::t_scan_ctl          i_ctl,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] i_idx,
    input  logic                        i_valid,
    input  logic [lfu_pkg::KEY_W-1:0]   i_key,
    input  logic [lfu_pkg::DATA_W-1:0]  i_data,
    input  logic [COUNT_BITS-1:0]       i_count,
    input  logic [lfu_pkg::STAMP_W-1:0] i_stamp,
    output lfu_pkg::t_scan_sts          o_sts,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] o_match_idx,
    output logic [lfu_pkg::DATA_W-1:0]  o_match_data,
    output logic [COUNT_BITS-1:0]       o_match_count,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] o_free_idx,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] o_victim_idx
);
    import lfu_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic               r_hit;
    logic               r_free;
    logic               r_vfound;
    logic [IDX_W-1:0]   r_match_idx;
    logic [DATA_W-1:0]  r_match_data;
    logic [COUNT_BITS-1:0] r_match_count;
    logic [IDX_W-1:0]   r_free_idx;
    logic [IDX_W-1:0]   r_victim_idx;
    logic [COUNT_BITS-1:0] r_best_count;
    logic [STAMP_W-1:0] r_best_age;

    logic [STAMP_W-1:0] age;
    logic               is_match;
    logic               is_free;
    logic               is_better;

    // age counts back from the current stamp, mod 2^32
    assign age       = i_ctl.stamp_now - i_stamp;
    assign is_match  = i_ctl.eval && i_valid && (i_key == i_ctl.find_key) && !r_hit;
    assign is_free   = i_ctl.eval && !i_valid && !r_free;
    assign is_better = i_ctl.eval && i_valid &&
                       (!r_vfound || (i_count < r_best_count) ||
                        ((i_count == r_best_count) && (age > r_best_age)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
            r_vfound <= 1'b0;
        end else if (i_ctl.start) begin
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
            r_vfound <= 1'b0;
        end else begin
            if (is_match) begin
                r_hit <= 1'b1;
            end
            if (is_free) begin
                r_free <= 1'b1;
            end
            if (is_better) begin
                r_vfound <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_match) begin
            r_match_idx   <= i_idx;
            r_match_data  <= i_data;
            r_match_count <= i_count;
        end
        if (is_free) begin
            r_free_idx <= i_idx;
        end
        if (is_better) begin
            r_victim_idx <= i_idx;
            r_best_count <= i_count;
            r_best_age   <= age;
        end
    end

    assign o_sts.hit          = r_hit;
    assign o_sts.free_found   = r_free;
    assign o_sts.victim_found = r_vfound;
    assign o_match_idx        = r_match_idx;
    assign o_match_data       = r_match_data;
    assign o_match_count      = r_match_count;
    assign o_free_idx         = r_free_idx;
    assign o_victim_idx       = r_victim_idx;

endmodule

FILE: hdl/lfu_cache_table.sv
// Requests: one at a time; a new request is accepted only in S_IDLE, after the
// previous one has loaded its response. The table memory is read one entry per
// cycle and every request walks all ENTRIES entries once.
// Reset: synchronous, active low; a clearing pass over all entries follows,
// during which no request is taken. Configuration words are taken at any time.
// ----------------------------------------------------------------------------
// LFU cache table
// Key-value cache with least-frequently-used replacement and least-recently
// used tie-break, built around a sequential table scan and a shared scan unit.
// ----------------------------------------------------------------------------
`include "lfu_cache_table_defines.svh"

module lfu_cache_table #(
    parameter int ENTRIES    = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lfu_req_if.sink   i_req,
    lfu_rsp_if.source o_rsp,
    lfu_cfg_if.sink   i_cfg
);
    import lfu_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_WRITE
    } t_state;

    // table memory
    logic                  r_valid_mem [ENTRIES];
    logic [KEY_W-1:0]      r_key_mem   [ENTRIES];
    logic [DATA_W-1:0]     r_data_mem  [ENTRIES];
    logic [COUNT_BITS-1:0] r_count_mem [ENTRIES];
    logic [STAMP_W-1:0]    r_stamp_mem [ENTRIES];

    logic                  r_rd_valid;
    logic [KEY_W-1:0]      r_rd_key;
    logic [DATA_W-1:0]     r_rd_data;
    logic [COUNT_BITS-1:0] r_rd_count;
    logic [STAMP_W-1:0]    r_rd_stamp;
    logic [IDX_W-1:0]      r_eval_idx;

    t_state             r_state;
    logic [CNT_W-1:0]   r_addr;
    logic               r_eval;
    logic [CFG_W-1:0]   r_capacity;
    logic [CFG_W-1:0]   r_occ;
    logic [STAMP_W-1:0] r_stamp;
    logic               r_action;
    logic [KEY_W-1:0]   r_key;
    logic [DATA_W-1:0]  r_value;
    logic               r_out_valid;
    logic               r_out_hit;
    logic [DATA_W-1:0]  r_out_value;

    t_scan_ctl             scan_ctl;
    t_scan_sts             scan_sts;
    logic [IDX_W-1:0]      match_idx;
    logic [DATA_W-1:0]     match_data;
    logic [COUNT_BITS-1:0] match_count;
    logic [IDX_W-1:0]      free_idx;
    logic [IDX_W-1:0]      victim_idx;

    logic                  out_free;
    logic                  last_addr;
    logic [CMP_W-1:0]      cap_ext;
    logic [CMP_W-1:0]      cap_clip;
    logic                  cap_zero;
    logic                  has_room;
    logic [COUNT_BITS-1:0] count_inc;

    logic                  w_we;
    logic [IDX_W-1:0]      w_addr;
    logic                  w_valid;
    logic [DATA_W-1:0]     w_data;
    logic [COUNT_BITS-1:0] w_count;
    logic                  w_fill;

    assign out_free  = !r_out_valid || o_rsp.ready;
    assign last_addr = (r_addr == CNT_W'(ENTRIES - 1));
    assign cap_ext   = CMP_W'(r_capacity);
    assign cap_clip  = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
    assign cap_zero  = (r_capacity == '0);
    assign has_room  = (CMP_W'(r_occ) < cap_clip);
    assign count_inc = (match_count == '1) ? match_count : match_count + COUNT_BITS'(1);

    assign scan_ctl.start     = (r_state == S_IDLE);
    assign scan_ctl.eval      = r_eval;
    assign scan_ctl.find_key  = r_key;
    assign scan_ctl.stamp_now = r_stamp;

    lfu_scan #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (scan_ctl),
        .i_idx         (r_eval_idx),
        .i_valid       (r_rd_valid),
        .i_key         (r_rd_key),
        .i_data        (r_rd_data),
        .i_count       (r_rd_count),
        .i_stamp       (r_rd_stamp),
        .o_sts         (scan_sts),
        .o_match_idx   (match_idx),
        .o_match_data  (match_data),
        .o_match_count (match_count),
        .o_free_idx    (free_idx),
        .o_victim_idx  (victim_idx)
    );

    // write port: clearing sweep, or at most one update at the end of a request
    always_comb begin
        w_we    = 1'b0;
        w_addr  = r_addr[IDX_W-1:0];
        w_valid = 1'b1;
        w_data  = r_value;
        w_count = COUNT_BITS'(1);
        w_fill  = 1'b0;
        priority if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_valid = 1'b0;
        end else if ((r_state == S_WRITE) && out_free) begin
            priority if (r_action == ACT_GET) begin
                if (scan_sts.hit) begin
                    w_we    = 1'b1;
                    w_addr  = match_idx;
                    w_data  = match_data;
                    w_count = count_inc;
                end
            end else if (cap_zero) begin
                w_we = 1'b0;
            end else if (scan_sts.hit) begin
                w_we    = 1'b1;
                w_addr  = match_idx;
                w_count = count_inc;
            end else if (has_room) begin
                w_we   = 1'b1;
                w_addr = free_idx;
                w_fill = 1'b1;
            end else begin
                w_we   = 1'b1;
                w_addr = victim_idx;
            end
        end else begin
            w_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_valid_mem[w_addr] <= w_valid;
            r_key_mem[w_addr]   <= r_key;
            r_data_mem[w_addr]  <= w_data;
            r_count_mem[w_addr] <= w_count;
            r_stamp_mem[w_addr] <= r_stamp;
        end
        r_rd_valid <= r_valid_mem[r_addr[IDX_W-1:0]];
        r_rd_key   <= r_key_mem[r_addr[IDX_W-1:0]];
        r_rd_data  <= r_data_mem[r_addr[IDX_W-1:0]];
        r_rd_count <= r_count_mem[r_addr[IDX_W-1:0]];
        r_rd_stamp <= r_stamp_mem[r_addr[IDX_W-1:0]];
        r_eval_idx <= r_addr[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_eval      <= 1'b0;
            r_capacity  <= CAP_RESET;
            r_occ       <= '0;
            r_stamp     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_capacity <= i_cfg.data;
            end
            // load a new word when the output is free, else drop it once taken
            if ((r_state == S_WRITE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            r_eval <= (r_state == S_SCAN);
            unique case (r_state)
                S_CLEAR: begin
                    if (last_addr) begin
                        r_addr  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + CNT_W'(1);
                    end
                end
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_action <= i_req.action;
                        r_key    <= i_req.key;
                        r_value  <= i_req.value;
                        r_addr   <= '0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_addr <= r_addr + CNT_W'(1);
                    if (last_addr) begin
                        r_state <= S_LAST;
                    end
                end
                S_LAST: begin
                    // last entry is evaluated this cycle
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    if (out_free) begin
                        r_out_hit   <= scan_sts.hit;
                        r_out_value <= ((r_action == ACT_GET) && scan_sts.hit) ?
                                       match_data : '0;
                        if (w_we) begin
                            r_stamp <= r_stamp + STAMP_W'(1);
                        end
                        if (w_fill) begin
                            r_occ <= r_occ + CFG_W'(1);
                        end
                        r_addr  <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready      = (r_state == S_IDLE);
    assign i_cfg.ready      = 1'b1;
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.hit        = r_out_hit;
    assign o_rsp.read_value = r_out_value;

    `LFU_ASSERT_NOW(a_occ_bound, 1'b1, CMP_W'(r_occ) <= CMP_W'(ENTRIES))
    `LFU_ASSERT_NOW(a_fill_has_slot, w_fill, scan_sts.free_found && !scan_sts.hit)
    `LFU_ASSERT_NOW(a_evict_has_victim, (r_state == S_WRITE) && w_we && !w_fill && !scan_sts.hit, scan_sts.victim_found)
    `LFU_ASSERT_NEXT(a_write_done, (r_state == S_WRITE) && out_free, (r_state == S_IDLE) && r_out_valid)

endmodule
